// File: hw/rtl/assert_macros.svh
// Assertion macros shared by the radial vignetting gain RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define RVG_ASSERT(label, expr) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error("rvg check failed");
`define RVG_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rvg implication failed");
`else
`define RVG_ASSERT(label, expr)
`define RVG_ASSERT_IMP(label, ante, cons)
`endif
`endif

// File: hw/rtl/rvg_pkg.sv
// Types and constants of the radial vignetting gain block.
package rvg_pkg;

  localparam int NARROW_SAMPLE_BITS = 8;
  localparam int GAIN_FRAC_NARROW   = 12;
  localparam int GAIN_FRAC_WIDE     = 10;
  localparam int GAIN_W_NARROW      = 23;
  localparam int GAIN_W_WIDE        = 15;
  localparam int GAIN_MAX_NARROW    = 2047 << 12;
  localparam int GAIN_MAX_WIDE      = 31 << 10;
  localparam int COEF_FRAC          = 24;

  // component roles, one nibble each
  localparam logic [3:0] ROLE_END     = 4'd0;
  localparam logic [3:0] ROLE_NEXT    = 4'd1;
  localparam logic [3:0] ROLE_UNKNOWN = 4'd2;

  typedef enum logic [2:0] {
    CFG_COEF_R2,
    CFG_COEF_R4,
    CFG_COEF_R6,
    CFG_PIX_STEP,
    CFG_CENTER_X,
    CFG_CENTER_Y,
    CFG_CORRECT_MODE,
    CFG_ROLE_WORD
  } cfg_idx_t;

  typedef struct packed {
    logic [15:0] sample;
    logic        row_start;
    logic [15:0] column;
    logic [15:0] line;
  } rvg_in_t;

  typedef struct packed {
    logic [15:0] sample_out;
    logic        pixel_end;
  } rvg_out_t;

  typedef struct packed {
    logic signed [31:0] coef_r2;
    logic signed [31:0] coef_r4;
    logic signed [31:0] coef_r6;
    logic               correct_mode;
  } rvg_coef_t;

  typedef struct packed {
    logic [30:0]        pix_step;
    logic signed [31:0] center_x;
    logic signed [31:0] center_y;
    logic [31:0]        role_word;
  } rvg_geom_t;

  typedef struct packed {
    logic start;
  } gain_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } gain_rsp_t;

  typedef enum logic [3:0] {
    G_IDLE,
    G_SQX,
    G_SQY,
    G_R2,
    G_MQ_LO,
    G_MQ_HI,
    G_MQ_FIN,
    G_SUM,
    G_DIV,
    G_FIX,
    G_DONE
  } gain_state_t;

  typedef enum logic [2:0] {
    OP_R4,
    OP_R6,
    OP_T2,
    OP_T4,
    OP_T6
  } mq_op_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_ROWX,
    B_ROWY,
    B_ROWF,
    B_GWAIT,
    B_WALK,
    B_MUL,
    B_EMIT
  } back_state_t;

endpackage

// File: hw/rtl/rvg_front.sv
// Input side: two-entry queue that decouples intake from processing.
module rvg_front (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  rvg_pkg::rvg_in_t in_data,
  output logic            q_valid,
  input  logic            q_ready,
  output rvg_pkg::rvg_in_t q_item
);
  import rvg_pkg::*;

  localparam int DEPTH = 2;
  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  rvg_in_t            entries_r [DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r;
  logic [PTR_W-1:0]   rd_ptr_r;
  logic [CNT_W-1:0]   count_r;
  logic               push;
  logic               pop;

  assign in_ready = (count_r != CNT_W'(DEPTH));
  assign q_valid  = (count_r != '0);
  assign q_item   = entries_r[rd_ptr_r];
  assign push     = in_valid && in_ready;
  assign pop      = q_valid && q_ready;

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      entries_r[wr_ptr_r] <= in_data;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      case ({push, pop})
        2'b10:   count_r <= count_r + 1'b1;
        2'b01:   count_r <= count_r - 1'b1;
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

// File: hw/rtl/rvg_gain.sv
// Pixel gain unit: shared 32x32 multiplier for the polynomial, restoring divider.
module rvg_gain #(
  parameter int SAMPLE_BITS = 16,
  localparam int GAIN_W = (SAMPLE_BITS <= rvg_pkg::NARROW_SAMPLE_BITS) ?
                          rvg_pkg::GAIN_W_NARROW : rvg_pkg::GAIN_W_WIDE
) (
  input  logic                clk,
  input  logic                rst_n,
  input  rvg_pkg::rvg_coef_t  coef,
  input  logic signed [31:0]  x_norm,
  input  logic signed [31:0]  y_norm,
  input  rvg_pkg::gain_req_t  req,
  output rvg_pkg::gain_rsp_t  rsp,
  output logic [GAIN_W-1:0]   gain
);
  import rvg_pkg::*;

  localparam int GAIN_FRAC = (SAMPLE_BITS <= NARROW_SAMPLE_BITS) ?
                             GAIN_FRAC_NARROW : GAIN_FRAC_WIDE;
  localparam logic [GAIN_W-1:0] GAIN_MAX = GAIN_W'((SAMPLE_BITS <= NARROW_SAMPLE_BITS) ?
                                                   GAIN_MAX_NARROW : GAIN_MAX_WIDE);
  localparam int NUM_EXP   = COEF_FRAC + GAIN_FRAC;
  localparam int QUO_W     = NUM_EXP + 1;
  localparam int CNT_W     = $clog2(QUO_W);
  localparam int MUL_SHIFT = COEF_FRAC - GAIN_FRAC;

  gain_state_t         gstate_r, gstate_nxt;
  mq_op_t              op_r;
  logic [63:0]         mp_r;
  logic [63:0]         acc_r;
  logic [63:0]         sum_sq;
  logic [63:0]         mq_res;
  logic [31:0]         r2_r;
  logic [39:0]         r4_r;
  logic [47:0]         r6_r;
  logic signed [55:0]  g_r;
  logic signed [55:0]  g_shift;
  logic [56:0]         rem_r;
  logic [56:0]         trial;
  logic [56:0]         g_div;
  logic [QUO_W-1:0]    quo_r;
  logic [CNT_W-1:0]    cnt_r;
  logic [GAIN_W-1:0]   gain_r;
  logic [31:0]         ax, ay, ac2, ac4, ac6;
  logic [31:0]         mq_a;
  logic [47:0]         mq_b;
  logic                mq_neg;
  logic [31:0]         mul_a, mul_b;

  function automatic logic [31:0] mag32(input logic signed [31:0] v);
    logic [31:0] u;
    u = v;
    return u[31] ? (~u + 32'd1) : u;
  endfunction

  function automatic mq_op_t next_op(input mq_op_t op);
    case (op)
      OP_R4:   return OP_R6;
      OP_R6:   return OP_T2;
      OP_T2:   return OP_T4;
      OP_T4:   return OP_T6;
      default: return OP_R4;
    endcase
  endfunction

  assign ax  = mag32(x_norm);
  assign ay  = mag32(y_norm);
  assign ac2 = mag32(coef.coef_r2);
  assign ac4 = mag32(coef.coef_r4);
  assign ac6 = mag32(coef.coef_r6);

  // operands of the current floor(a*b / 2^24) step
  always_comb begin
    mq_a   = '0;
    mq_b   = '0;
    mq_neg = 1'b0;
    case (op_r)
      OP_R4: begin
        mq_a = r2_r;
        mq_b = 48'(r2_r);
      end
      OP_R6: begin
        mq_a = r2_r;
        mq_b = 48'(r4_r);
      end
      OP_T2: begin
        mq_a   = ac2;
        mq_b   = 48'(r2_r);
        mq_neg = coef.coef_r2[31];
      end
      OP_T4: begin
        mq_a   = ac4;
        mq_b   = 48'(r4_r);
        mq_neg = coef.coef_r4[31];
      end
      OP_T6: begin
        mq_a   = ac6;
        mq_b   = r6_r;
        mq_neg = coef.coef_r6[31];
      end
      default: ;
    endcase
  end

  // multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (gstate_r)
      G_SQX: begin
        mul_a = ax;
        mul_b = ax;
      end
      G_SQY: begin
        mul_a = ay;
        mul_b = ay;
      end
      G_MQ_LO: begin
        mul_a = mq_a;
        mul_b = 32'(mq_b[23:0]);
      end
      G_MQ_HI: begin
        mul_a = mq_a;
        mul_b = 32'(mq_b[47:24]);
      end
      default: ;
    endcase
  end

  assign sum_sq  = acc_r + mp_r;
  assign mq_res  = mp_r + (acc_r >> COEF_FRAC);
  assign g_shift = g_r >>> MUL_SHIFT;
  assign g_div   = {1'b0, g_r};
  assign trial   = {rem_r[55:0], (cnt_r == CNT_W'(NUM_EXP))};

  // next state
  always_comb begin
    gstate_nxt = gstate_r;
    unique case (gstate_r)
      G_IDLE:   if (req.start) gstate_nxt = G_SQX;
      G_SQX:    gstate_nxt = G_SQY;
      G_SQY:    gstate_nxt = G_R2;
      G_R2:     gstate_nxt = G_MQ_LO;
      G_MQ_LO:  gstate_nxt = G_MQ_HI;
      G_MQ_HI:  gstate_nxt = G_MQ_FIN;
      G_MQ_FIN: gstate_nxt = (op_r == OP_T6) ? G_SUM : G_MQ_LO;
      G_SUM:    gstate_nxt = (coef.correct_mode && g_r > 0) ? G_DIV : G_DONE;
      G_DIV:    if (cnt_r == '0) gstate_nxt = G_FIX;
      G_FIX:    gstate_nxt = G_DONE;
      G_DONE:   gstate_nxt = G_IDLE;
      default:  gstate_nxt = G_IDLE;
    endcase
  end

  // status outputs
  always_comb begin
    rsp.busy = (gstate_r != G_IDLE);
    rsp.done = (gstate_r == G_DONE);
  end

  assign gain = gain_r;

  // datapath
  always_ff @(posedge clk) begin
    mp_r <= mul_a * mul_b;
    case (gstate_r)
      G_SQY:   acc_r <= mp_r;
      G_R2: begin
        r2_r <= sum_sq[63:32];
        g_r  <= 56'(64'd1 << COEF_FRAC);
      end
      G_MQ_HI: acc_r <= mp_r;
      G_MQ_FIN: begin
        case (op_r)
          OP_R4:   r4_r <= mq_res[39:0];
          OP_R6:   r6_r <= mq_res[47:0];
          default: g_r  <= mq_neg ? (g_r - $signed(mq_res[55:0]))
                                  : (g_r + $signed(mq_res[55:0]));
        endcase
      end
      G_SUM: begin
        rem_r <= '0;
        quo_r <= '0;
        cnt_r <= CNT_W'(NUM_EXP);
      end
      G_DIV: begin
        if (trial >= g_div) begin
          rem_r <= trial - g_div;
          quo_r <= {quo_r[QUO_W-2:0], 1'b1};
        end else begin
          rem_r <= trial;
          quo_r <= {quo_r[QUO_W-2:0], 1'b0};
        end
        cnt_r <= cnt_r - 1'b1;
      end
      default: ;
    endcase
  end

  // control and the held pixel gain
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gstate_r <= G_IDLE;
      op_r     <= OP_R4;
      gain_r   <= '0;
    end else begin
      gstate_r <= gstate_nxt;
      if (gstate_r == G_R2) begin
        op_r <= OP_R4;
      end else if (gstate_r == G_MQ_FIN) begin
        op_r <= next_op(op_r);
      end
      if (gstate_r == G_SUM) begin
        if (coef.correct_mode) begin
          if (g_r == '0) begin
            gain_r <= GAIN_MAX;
          end else if (g_r < 0) begin
            gain_r <= '0;
          end
        end else if (g_r <= 0) begin
          gain_r <= '0;
        end else if (g_shift > 56'(GAIN_MAX)) begin
          gain_r <= GAIN_MAX;
        end else begin
          gain_r <= g_shift[GAIN_W-1:0];
        end
      end
      if (gstate_r == G_FIX) begin
        gain_r <= (quo_r > QUO_W'(GAIN_MAX)) ? GAIN_MAX : quo_r[GAIN_W-1:0];
      end
    end
  end

endmodule

// File: hw/rtl/rvg_back.sv
// Processing side: coordinates, role walk, sample scaling and output register.
module rvg_back #(
  parameter int SAMPLE_BITS = 16,
  localparam int GAIN_W = (SAMPLE_BITS <= rvg_pkg::NARROW_SAMPLE_BITS) ?
                          rvg_pkg::GAIN_W_NARROW : rvg_pkg::GAIN_W_WIDE
) (
  input  logic                clk,
  input  logic                rst_n,
  input  rvg_pkg::rvg_geom_t  geom,
  input  rvg_pkg::rvg_in_t    q_item,
  input  logic                q_valid,
  output logic                q_ready,
  output rvg_pkg::gain_req_t  gain_req,
  input  rvg_pkg::gain_rsp_t  gain_rsp,
  input  logic [GAIN_W-1:0]   gain,
  output logic signed [31:0]  x_norm,
  output logic signed [31:0]  y_norm,
  output logic                out_valid,
  input  logic                out_ready,
  output rvg_pkg::rvg_out_t   out_data
);
  import rvg_pkg::*;

  localparam int GAIN_FRAC = (SAMPLE_BITS <= NARROW_SAMPLE_BITS) ?
                             GAIN_FRAC_NARROW : GAIN_FRAC_WIDE;
  localparam int PROD_W     = 48;
  localparam int STEP_LIMIT = 8;
  localparam int STEP_W     = $clog2(STEP_LIMIT + 1);
  localparam logic [SAMPLE_BITS-1:0] SAMPLE_MAX = '1;
  localparam logic [PROD_W:0] ROUND_HALF = {{PROD_W{1'b0}}, 1'b1} << (GAIN_FRAC - 1);

  back_state_t              bstate_r, bstate_nxt;
  logic [SAMPLE_BITS-1:0]   s_r;
  logic [15:0]              col_r;
  logic [15:0]              line_r;
  logic signed [31:0]       x_r, y_r;
  logic [31:0]              roles_r;
  logic [STEP_W-1:0]        step_r;
  logic [PROD_W-1:0]        prod_r;
  logic                     scale_r, pend_r, post_r;
  logic                     out_valid_r;
  rvg_out_t                 out_data_r;

  logic [31:0]              rl, rl_post;
  logic [3:0]               nib, nib_post;
  logic                     walk_last, walk_adv, out_free, emit_load;
  logic [32:0]              x_sum;
  logic signed [31:0]       x_step;
  logic [PROD_W:0]          diff_x, diff_y;
  logic [PROD_W:0]          rounded, shifted;
  logic [SAMPLE_BITS-1:0]   scaled_val, result;

  // saturate a 49-bit two's complement value to signed 32 bits
  function automatic logic [31:0] sat32(input logic [48:0] v);
    if (!v[48] && (|v[47:31])) return 32'h7FFF_FFFF;
    if (v[48] && !(&v[47:31])) return 32'h8000_0000;
    return v[31:0];
  endfunction

  // role decode
  assign rl        = (roles_r == '0) ? geom.role_word : roles_r;
  assign nib       = rl[3:0];
  assign rl_post   = rl >> 4;
  assign nib_post  = rl_post[3:0];
  assign walk_last = (step_r == STEP_W'(STEP_LIMIT));
  assign walk_adv  = !walk_last && (nib == ROLE_END || nib == ROLE_NEXT);
  assign out_free  = !out_valid_r || out_ready;

  // coordinate arithmetic
  assign x_sum  = {x_r[31], x_r} + {2'b00, geom.pix_step};
  assign x_step = sat32({{16{x_sum[32]}}, x_sum});
  assign diff_x = {1'b0, prod_r} - {{17{geom.center_x[31]}}, geom.center_x};
  assign diff_y = {1'b0, prod_r} - {{17{geom.center_y[31]}}, geom.center_y};

  // rounding and clamp of the scaled sample
  assign rounded    = {1'b0, prod_r} + ROUND_HALF;
  assign shifted    = rounded >> GAIN_FRAC;
  assign scaled_val = (shifted > (PROD_W+1)'(SAMPLE_MAX)) ? SAMPLE_MAX
                                                          : shifted[SAMPLE_BITS-1:0];
  assign result     = scale_r ? scaled_val : s_r;

  // next state
  always_comb begin
    bstate_nxt = bstate_r;
    unique case (bstate_r)
      B_IDLE:  if (q_valid) bstate_nxt = q_item.row_start ? B_ROWX : B_WALK;
      B_ROWX:  bstate_nxt = B_ROWY;
      B_ROWY:  bstate_nxt = B_ROWF;
      B_ROWF:  bstate_nxt = B_GWAIT;
      B_GWAIT: if (gain_rsp.done) bstate_nxt = post_r ? B_IDLE : B_WALK;
      B_WALK: begin
        if (walk_last) bstate_nxt = B_EMIT;
        else if (walk_adv) bstate_nxt = B_GWAIT;
        else bstate_nxt = B_MUL;
      end
      B_MUL:   bstate_nxt = B_EMIT;
      B_EMIT:  if (out_free) bstate_nxt = pend_r ? B_GWAIT : B_IDLE;
      default: bstate_nxt = B_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    q_ready        = (bstate_r == B_IDLE);
    emit_load      = (bstate_r == B_EMIT) && out_free;
    gain_req.start = (bstate_r == B_ROWF) ||
                     ((bstate_r == B_WALK) && walk_adv) ||
                     (emit_load && pend_r);
  end

  assign x_norm    = x_r;
  assign y_norm    = y_r;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // item payload, products and output payload
  always_ff @(posedge clk) begin
    case (bstate_r)
      B_IDLE: begin
        if (q_valid) begin
          s_r    <= q_item.sample[SAMPLE_BITS-1:0];
          col_r  <= q_item.column;
          line_r <= q_item.line;
        end
      end
      B_ROWX: prod_r <= col_r * geom.pix_step;
      B_ROWY: prod_r <= line_r * geom.pix_step;
      B_MUL:  prod_r <= s_r * gain;
      default: ;
    endcase
    if (emit_load) begin
      out_data_r.sample_out <= 16'(result);
      out_data_r.pixel_end  <= pend_r;
    end
  end

  // control, coordinates and role state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bstate_r    <= B_IDLE;
      x_r         <= '0;
      y_r         <= '0;
      roles_r     <= '0;
      step_r      <= '0;
      scale_r     <= 1'b0;
      pend_r      <= 1'b0;
      post_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      bstate_r <= bstate_nxt;
      case (bstate_r)
        B_IDLE: begin
          if (q_valid) begin
            step_r <= '0;
            if (q_item.row_start) begin
              roles_r <= '0;
            end
          end
        end
        B_ROWY: x_r <= sat32(diff_x);
        B_ROWF: begin
          y_r    <= sat32(diff_y);
          post_r <= 1'b0;
        end
        B_WALK: begin
          if (walk_last) begin
            // no component role in the word: pass through
            roles_r <= rl;
            scale_r <= 1'b0;
            pend_r  <= 1'b0;
          end else if (walk_adv) begin
            roles_r <= (nib == ROLE_END) ? '0 : rl_post;
            x_r     <= x_step;
            step_r  <= step_r + 1'b1;
            post_r  <= 1'b0;
          end else begin
            scale_r <= (nib != ROLE_UNKNOWN);
            if (rl_post == '0 || nib_post == ROLE_END) begin
              roles_r <= '0;
              pend_r  <= 1'b1;
            end else if (nib_post == ROLE_NEXT) begin
              roles_r <= rl_post >> 4;
              pend_r  <= 1'b1;
            end else begin
              roles_r <= rl_post;
              pend_r  <= 1'b0;
            end
          end
        end
        B_EMIT: begin
          if (out_free && pend_r) begin
            x_r    <= x_step;
            post_r <= 1'b1;
          end
        end
        default: ;
      endcase
      if (emit_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

endmodule

// File: hw/rtl/radial_vignetting_gain.sv
// Radial vignetting gain top level: configuration registers and block assembly.
//
// Input channel in_valid/in_ready/in_data carries one colour component per
// transfer with its row-start flag, column and line. Output channel
// out_valid/out_ready/out_data returns one corrected (or passed) component
// and a pixel-end flag per input transfer, in order.
// A two-entry input queue takes new components while the back end works.
// A plain component passes from the queue through the role walk and the
// multiply state to the output register. Every pixel step and every row
// start recomputes the pixel gain in the gain unit, through the shared
// 32x32 multiplier sequence and, in divide mode, the one-bit-per-cycle
// restoring divider, which runs longer for 8-bit samples. A component that
// ends a pixel therefore also waits for one gain computation, and a row
// start adds coordinate setup plus one gain computation.
// Reset clears the queue, coordinates, roles and gain; configuration
// returns to divide mode with role word 3. A stalled receiver holds the
// result in the output register; the queue keeps filling until full.
`include "assert_macros.svh"
module radial_vignetting_gain #(
  parameter int SAMPLE_BITS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  rvg_pkg::rvg_in_t   in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output rvg_pkg::rvg_out_t  out_data,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data
);
  import rvg_pkg::*;

  localparam int GAIN_W = (SAMPLE_BITS <= NARROW_SAMPLE_BITS) ? GAIN_W_NARROW : GAIN_W_WIDE;

  rvg_coef_t            coef_r;
  rvg_geom_t            geom_r;
  rvg_in_t              q_item;
  logic                 q_valid, q_ready;
  gain_req_t            g_req;
  gain_rsp_t            g_rsp;
  logic [GAIN_W-1:0]    gain;
  logic signed [31:0]   x_norm, y_norm;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_r.coef_r2      <= '0;
      coef_r.coef_r4      <= '0;
      coef_r.coef_r6      <= '0;
      coef_r.correct_mode <= 1'b1;
      geom_r.pix_step     <= '0;
      geom_r.center_x     <= '0;
      geom_r.center_y     <= '0;
      geom_r.role_word    <= 32'd3;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_COEF_R2:      coef_r.coef_r2      <= cfg_data;
        CFG_COEF_R4:      coef_r.coef_r4      <= cfg_data;
        CFG_COEF_R6:      coef_r.coef_r6      <= cfg_data;
        CFG_PIX_STEP:     geom_r.pix_step     <= cfg_data[30:0];
        CFG_CENTER_X:     geom_r.center_x     <= cfg_data;
        CFG_CENTER_Y:     geom_r.center_y     <= cfg_data;
        CFG_CORRECT_MODE: coef_r.correct_mode <= cfg_data[0];
        CFG_ROLE_WORD:    geom_r.role_word    <= cfg_data;
        default: ;
      endcase
    end
  end

  rvg_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .q_valid  (q_valid),
    .q_ready  (q_ready),
    .q_item   (q_item)
  );

  rvg_gain #(.SAMPLE_BITS(SAMPLE_BITS)) u_gain (
    .clk    (clk),
    .rst_n  (rst_n),
    .coef   (coef_r),
    .x_norm (x_norm),
    .y_norm (y_norm),
    .req    (g_req),
    .rsp    (g_rsp),
    .gain   (gain)
  );

  rvg_back #(.SAMPLE_BITS(SAMPLE_BITS)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .geom      (geom_r),
    .q_item    (q_item),
    .q_valid   (q_valid),
    .q_ready   (q_ready),
    .gain_req  (g_req),
    .gain_rsp  (g_rsp),
    .gain      (gain),
    .x_norm    (x_norm),
    .y_norm    (y_norm),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // the back end never restarts a gain computation in flight
  `RVG_ASSERT(a_no_restart, !(g_req.start && g_rsp.busy))
  // completion is only reported by a running gain unit
  `RVG_ASSERT_IMP(a_done_follows_busy, g_rsp.done, $past(g_rsp.busy))
  // a new request never coincides with completion
  `RVG_ASSERT(a_req_rsp_excl, !(g_req.start && g_rsp.done))

endmodule

// File: tb/tb_radial_vignetting_gain.sv
// Self-checking testbench for the radial vignetting gain block.
`timescale 1ns / 100ps
module tb_radial_vignetting_gain;
  import rvg_pkg::*;

  localparam int SBITS = 16;
  localparam longint SMAX = (64'd1 << SBITS) - 1;
  localparam int GFRAC = (SBITS <= 8) ? 12 : 10;
  localparam longint GMAX = (SBITS <= 8) ? (2047 << 12) : (31 << 10);
  localparam int CYCLE_LIMIT = 6000000;

  logic clk, rst_n;
  logic in_valid, in_ready, out_valid, out_ready;
  rvg_in_t in_data;
  rvg_out_t out_data;
  logic cfg_we;
  logic [2:0] cfg_index;
  logic [31:0] cfg_data;

  radial_vignetting_gain #(.SAMPLE_BITS(SBITS)) dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // predictor copy of the registers and pixel state
  longint k_r2, k_r4, k_r6, cen_x, cen_y;
  longint unsigned step_sz;
  bit divide_mode;
  logic [31:0] roles_cfg, roles_rem;
  longint pos_x, pos_y;
  longint unsigned cur_gain;

  rvg_out_t expected_q[$];
  int errors;
  int unsigned cycles;
  bit quiet_rx, no_idle, hold_rx;

  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  function automatic longint clamp32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint unsigned abs64(longint v);
    return v < 0 ? longint'(-v) : v;
  endfunction

  function automatic longint unsigned mul_q24(longint unsigned a, longint unsigned b);
    return a * (b >> 24) + ((a * (b & 64'hFFFFFF)) >> 24);
  endfunction

  function automatic longint coef_term(longint k, longint unsigned pw);
    longint t;
    t = longint'(mul_q24(abs64(k), pw));
    return k < 0 ? -t : t;
  endfunction

  function automatic void update_gain();
    longint unsigned ax, ay, r2, r4, r6, c;
    longint g;
    ax = abs64(pos_x);
    ay = abs64(pos_y);
    r2 = ((ax * ax + ay * ay) >> 28) >> 4;
    r4 = mul_q24(r2, r2);
    r6 = mul_q24(r4, r2);
    g = (64'sd1 << 24) + coef_term(k_r2, r2) + coef_term(k_r4, r4) + coef_term(k_r6, r6);
    if (divide_mode) begin
      if (g == 0) c = GMAX;
      else if (g < 0) c = 0;
      else c = (64'd1 << (24 + GFRAC)) / longint'(g);
    end else begin
      c = (g <= 0) ? 0 : (longint'(g) >> (24 - GFRAC));
    end
    cur_gain = (c > GMAX) ? GMAX : c;
  endfunction

  function automatic void step_pixel();
    pos_x = clamp32(pos_x + longint'(step_sz));
    update_gain();
  endfunction

  function automatic void reset_model();
    k_r2 = 0; k_r4 = 0; k_r6 = 0; cen_x = 0; cen_y = 0;
    step_sz = 0; divide_mode = 1; roles_cfg = 3;
    pos_x = 0; pos_y = 0; roles_rem = 0; cur_gain = 0;
  endfunction

  // corrected component for one input transfer
  function automatic rvg_out_t correct_component(rvg_in_t it);
    rvg_out_t r;
    longint unsigned s, p;
    logic [3:0] nib;
    bit hit;
    s = it.sample & SMAX;
    r.sample_out = s[15:0];
    r.pixel_end = 0;
    hit = 0;
    nib = 0;
    if (it.row_start) begin
      pos_x = clamp32(longint'(it.column) * longint'(step_sz) - cen_x);
      pos_y = clamp32(longint'(it.line) * longint'(step_sz) - cen_y);
      roles_rem = 0;
      update_gain();
    end
    for (int i = 0; i < 9; i++) begin
      if (roles_rem == 0) roles_rem = roles_cfg;
      nib = roles_rem[3:0];
      if (i == 8) break;
      if (nib == ROLE_END) begin
        roles_rem = 0;
        step_pixel();
      end else if (nib == ROLE_NEXT) begin
        roles_rem = roles_rem >> 4;
        step_pixel();
      end else begin
        hit = 1;
        break;
      end
    end
    if (hit) begin
      if (nib != ROLE_UNKNOWN) begin
        p = (s * cur_gain + (64'd1 << (GFRAC - 1))) >> GFRAC;
        r.sample_out = (p > SMAX) ? SMAX[15:0] : p[15:0];
      end
      roles_rem = roles_rem >> 4;
      nib = roles_rem[3:0];
      if (roles_rem == 0 || nib == ROLE_END) begin
        roles_rem = 0;
        r.pixel_end = 1;
        step_pixel();
      end else if (nib == ROLE_NEXT) begin
        roles_rem = roles_rem >> 4;
        r.pixel_end = 1;
        step_pixel();
      end
    end
    return r;
  endfunction

  // one register write, then the write enable drops before the task returns
  task automatic write_reg(cfg_idx_t idx, logic [31:0] val);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 0;
    case (idx)
      CFG_COEF_R2: k_r2 = longint'(signed'(val));
      CFG_COEF_R4: k_r4 = longint'(signed'(val));
      CFG_COEF_R6: k_r6 = longint'(signed'(val));
      CFG_PIX_STEP: step_sz = val[30:0];
      CFG_CENTER_X: cen_x = longint'(signed'(val));
      CFG_CENTER_Y: cen_y = longint'(signed'(val));
      CFG_CORRECT_MODE: divide_mode = val[0];
      CFG_ROLE_WORD: roles_cfg = val;
      default: ;
    endcase
    @(posedge clk);
  endtask

  // drain, then let a trailing gain computation finish
  task automatic wait_idle();
    in_valid <= 0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (150) @(posedge clk);
  endtask

  // one input transfer; optional expected value typed in
  task automatic send_item(rvg_in_t it, bit has_exp, rvg_out_t exp_val);
    rvg_out_t pred;
    if (!no_idle) begin
      while ($urandom_range(99) < 13) begin
        in_valid <= 0;
        @(posedge clk);
      end
    end
    in_valid <= 1;
    in_data <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pred = correct_component(it);
    if (has_exp && pred != exp_val)
      $display("%0t directed row disagrees: expected %h predicted %h", $time, exp_val, pred);
    expected_q.push_back(has_exp ? exp_val : pred);
  endtask

  function automatic rvg_in_t rand_item(int row_pct, bit small_pos);
    rvg_in_t it;
    it.sample = $urandom;
    it.row_start = ($urandom_range(99) < row_pct);
    it.column = small_pos ? 16'($urandom_range(64)) : 16'($urandom);
    it.line = small_pos ? 16'($urandom_range(64)) : 16'($urandom);
    return it;
  endfunction

  // result side: random stalls, plus a long hold-off on request
  always @(posedge clk) begin
    if (!rst_n) out_ready <= 0;
    else if (hold_rx) out_ready <= 0;
    else out_ready <= quiet_rx ? 1'b1 : ($urandom_range(99) >= 13);
  end

  always @(posedge clk) begin
    rvg_out_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_q.size() == 0) begin
        $display("%0t unexpected transfer: actual %h", $time, out_data);
        errors++;
      end else begin
        want = expected_q.pop_front();
        if (out_data.sample_out !== want.sample_out) begin
          $display("%0t sample_out: expected %h actual %h", $time,
                   want.sample_out, out_data.sample_out);
          errors++;
        end
        if (out_data.pixel_end !== want.pixel_end) begin
          $display("%0t pixel_end: expected %b actual %b", $time,
                   want.pixel_end, out_data.pixel_end);
          errors++;
        end
      end
    end
  end

  typedef struct {
    rvg_in_t it;
    bit has_exp;
    rvg_out_t exp_val;
  } stim_row_t;

  initial begin
    stim_row_t rows[$];
    rvg_out_t zero_out;
    zero_out = '0;
    errors = 0;
    cycles = 0;
    quiet_rx = 0;
    no_idle = 0;
    hold_rx = 0;
    rst_n = 0;
    in_valid = 0;
    in_data = '0;
    cfg_we = 0;
    cfg_index = CFG_COEF_R2;
    cfg_data = 0;
    reset_model();
    repeat (9) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // before any row start the gain is zero: colour component gives 0, pixel ends
    rows.push_back('{'{16'hFFFF, 1'b0, 16'h0, 16'h0}, 1, '{16'h0, 1'b1}});
    rows.push_back('{'{16'h0000, 1'b0, 16'hFFFF, 16'hFFFF}, 1, '{16'h0, 1'b1}});
    // row start at center with zero coefficients: unity gain
    rows.push_back('{'{16'hFFFF, 1'b1, 16'h0, 16'h0}, 1, '{16'hFFFF, 1'b1}});
    rows.push_back('{'{16'h1234, 1'b1, 16'hFFFF, 16'hFFFF}, 1, '{16'h1234, 1'b1}});
    rows.push_back('{'{16'h0001, 1'b0, 16'h0, 16'h0}, 1, '{16'h0001, 1'b1}});
    foreach (rows[i]) send_item(rows[i].it, rows[i].has_exp, rows[i].exp_val);
    rows.delete();
    wait_idle();

    // multiply mode, strong coefficients, RGB roles plus an unknown and next-pixel
    write_reg(CFG_CORRECT_MODE, 0);
    write_reg(CFG_COEF_R2, 32'h0100_0000);
    write_reg(CFG_COEF_R4, 32'hFF80_0000);
    write_reg(CFG_COEF_R6, 32'h0040_0000);
    write_reg(CFG_PIX_STEP, 32'h0080_0000);
    write_reg(CFG_CENTER_X, 32'h0800_0000);
    write_reg(CFG_CENTER_Y, 32'hF800_0000);
    write_reg(CFG_ROLE_WORD, 32'h0001_2543);
    for (int i = 0; i < 10; i++)
      rows.push_back('{rand_item(i == 0 ? 100 : 10, 1), 0, zero_out});
    // saturating coordinates, gain clamp
    rows.push_back('{'{16'hFFFF, 1'b1, 16'hFFFF, 16'hFFFF}, 0, zero_out});
    foreach (rows[i]) send_item(rows[i].it, rows[i].has_exp, rows[i].exp_val);
    rows.delete();
    wait_idle();

    // extremes: negative gain, word of only empty pixels, end with high nibbles
    write_reg(CFG_COEF_R2, 32'h8000_0000);
    write_reg(CFG_PIX_STEP, 32'h7FFF_FFFF);
    write_reg(CFG_ROLE_WORD, 32'h1111_1111);
    send_item('{16'hABCD, 1'b1, 16'h1, 16'h1}, 1, '{16'hABCD, 1'b0});
    wait_idle();
    write_reg(CFG_ROLE_WORD, 32'hFFFF_FFF0);
    send_item('{16'h5555, 1'b0, 16'h0, 16'h0}, 1, '{16'h5555, 1'b0});
    wait_idle();
    write_reg(CFG_CORRECT_MODE, 1);
    write_reg(CFG_COEF_R2, 32'h7FFF_FFFF);
    write_reg(CFG_COEF_R4, 32'h7FFF_FFFF);
    write_reg(CFG_COEF_R6, 32'h8000_0000);
    write_reg(CFG_CENTER_X, 32'h7FFF_FFFF);
    write_reg(CFG_CENTER_Y, 32'h8000_0000);
    write_reg(CFG_ROLE_WORD, 32'h0000_0F21);
    for (int i = 0; i < 6; i++) send_item(rand_item(30, 0), 0, zero_out);
    wait_idle();

    // random phases, each with its own register setting
    for (int ph = 0; ph < 13; ph++) begin
      write_reg(CFG_CORRECT_MODE, $urandom_range(1));
      write_reg(CFG_COEF_R2, ($urandom_range(3) == 0) ? $urandom
                             : 32'($signed($urandom_range(64'h01FF_FFFF)) - 32'sh0100_0000));
      write_reg(CFG_COEF_R4, ($urandom_range(3) == 0) ? $urandom
                             : 32'($signed($urandom_range(64'h00FF_FFFF)) - 32'sh0080_0000));
      write_reg(CFG_COEF_R6, ($urandom_range(3) == 0) ? $urandom
                             : 32'($signed($urandom_range(64'h007F_FFFF)) - 32'sh0040_0000));
      write_reg(CFG_PIX_STEP, ($urandom_range(4) == 0) ? $urandom
                              : $urandom_range(32'h0040_0000));
      write_reg(CFG_CENTER_X, ($urandom_range(4) == 0) ? $urandom
                              : $urandom_range(32'h1000_0000));
      write_reg(CFG_CENTER_Y, ($urandom_range(4) == 0) ? $urandom
                              : $urandom_range(32'h1000_0000));
      case ($urandom_range(4))
        0: write_reg(CFG_ROLE_WORD, $urandom);
        1: write_reg(CFG_ROLE_WORD, 32'h0000_0543);
        2: write_reg(CFG_ROLE_WORD, 32'h0000_1643);
        3: write_reg(CFG_ROLE_WORD, 32'h0002_5431);
        default: write_reg(CFG_ROLE_WORD, 32'h0000_0003);
      endcase
      no_idle = (ph == 4);
      quiet_rx = (ph == 4);
      if (ph == 7) begin
        // long receiver hold-off while the sender keeps offering
        fork
          begin
            hold_rx = 1;
            repeat (400) @(posedge clk);
            hold_rx = 0;
          end
        join_none
      end
      for (int i = 0; i < 150; i++) begin
        send_item(rand_item(8, $urandom_range(9) != 0), 0, zero_out);
        // sender pause until everything is back
        if (ph == 9 && i == 75) begin
          in_valid <= 0;
          while (expected_q.size() != 0) @(posedge clk);
        end
      end
      wait_idle();
    end
    no_idle = 0;
    quiet_rx = 0;

    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule

// File: sim.f
+incdir+hw/rtl
hw/rtl/rvg_pkg.sv
hw/rtl/rvg_front.sv
hw/rtl/rvg_gain.sv
hw/rtl/rvg_back.sv
hw/rtl/radial_vignetting_gain.sv
tb/tb_radial_vignetting_gain.sv
